@@ design/ljd_pkg.sv @@
// Shared types and constants of the least-loaded job dispatcher.
`default_nettype none
package ljd_pkg;

    localparam int TAG_W     = 16;
    localparam int HANDLER_W = 8;
    localparam int SEL_W     = 2;
    localparam int ID_W      = 2;
    localparam int LEVEL_W   = 5;
    localparam int CFG_W     = 3;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 32;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_WORKER = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_SUBMIT    = 2'd0,
        K_POP       = 2'd1,
        K_NO_WORKER = 2'd2,
        K_POP_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [TAG_W-1:0]       tag;
        logic [HANDLER_W-1:0]   handler;
        logic [SEL_W-1:0]       sel;
        logic [CFG_W-1:0]       nact;
    } fe_item_t;

endpackage
`default_nettype wire

@@ design/least_loaded_job_dispatcher_core.sv @@
// Top level of the least-loaded job dispatcher.
//
// Jobs arrive on the s_ stream; s_tuser is the command (0 submit, 1 pop).
// A submit goes to the lowest-numbered active worker with an empty queue,
// else to the first active worker with the smallest count; a pop returns
// the oldest job of worker_sel. Every transaction gives one result on m_.
// cfg_we/cfg_wdata write active_workers (reset 4); the user must write it
// only while idle, the block itself does not enforce this. The back end
// handles a transaction in state BK_SEL, which scans the worker counts and
// issues the store read, then in BK_FIN, which writes the store and loads
// the result register; it takes no new transaction before BK_FIN is done.
// A two-entry queue separates front and back; while m_tready is low the
// result register holds and the back end waits, the front queue keeps
// taking up to two transactions. Reset empties all queues and counters;
// the job store itself is not cleared, no entry is read before written.
`default_nettype none
module least_loaded_job_dispatcher_core #(
    parameter int NUM_WORKERS = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ljd_pkg::CFG_W-1:0]       cfg_wdata,   // active_workers
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ljd_pkg::IN_DATA_W-1:0]   s_tdata,     // job_tag, handler_index, worker_sel
    input  wire logic                            s_tuser,     // command
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ljd_pkg::OUT_DATA_W-1:0]       m_tdata,     // worker_id, found_idle, out_tag,
                                                              // out_handler, queue_level
    output logic [1:0]                           m_tuser      // status
);
    import ljd_pkg::*;

    logic [CFG_W-1:0] active_workers_reg;
    logic             q_valid;
    logic             q_ready;
    fe_item_t         q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_workers_reg <= CFG_W'(4);
        else if (cfg_we)
            active_workers_reg <= cfg_wdata;
    end

    ljd_front #(
        .NUM_WORKERS (NUM_WORKERS),
        .TAG_BITS    (TAG_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .active_workers (active_workers_reg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_ready        (q_ready)
    );

    ljd_back #(
        .NUM_WORKERS (NUM_WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

@@ design/ljd_front.sv @@
// Front end: accepts transactions, classifies them and buffers them in a two-entry queue.
`default_nettype none
module ljd_front #(
    parameter int NUM_WORKERS = 4,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ljd_pkg::CFG_W-1:0]      active_workers,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ljd_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tuser,
    output logic                                q_valid,
    output ljd_pkg::fe_item_t                   q_item,
    input  wire logic                           q_ready
);
    import ljd_pkg::*;

    localparam logic [TAG_W-1:0] TAG_MASK =
        (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((64'd1 << TAG_BITS) - 64'd1);

    fe_item_t   in_item;
    fe_item_t   buf_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    always_comb
    begin
        in_item.tag     = s_tdata[TAG_W-1:0] & TAG_MASK;
        in_item.handler = s_tdata[TAG_W+HANDLER_W-1:TAG_W];
        in_item.sel     = s_tdata[TAG_W+HANDLER_W+SEL_W-1:TAG_W+HANDLER_W];
        if (int'(active_workers) > NUM_WORKERS)
            in_item.nact = CFG_W'(NUM_WORKERS);
        else
            in_item.nact = active_workers;
        if (s_tuser == CMD_SUBMIT)
            in_item.kind = (in_item.nact == '0) ? K_NO_WORKER : K_SUBMIT;
        else
            in_item.kind = (int'(in_item.sel) >= NUM_WORKERS) ? K_POP_NONE : K_POP;
    end

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next   = push ? ~wp_reg : wp_reg;
        rp_next   = pop ? ~rp_reg : rp_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wp_reg] <= in_item;
    end

endmodule
`default_nettype wire

@@ design/ljd_back.sv @@
// Back end: worker selection, per-worker FIFO store and result register.
`default_nettype none
module ljd_back #(
    parameter int NUM_WORKERS = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    input  ljd_pkg::fe_item_t                    q_item,
    output logic                                 q_ready,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ljd_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [1:0]                           m_tuser
);
    import ljd_pkg::*;

    localparam int WID_W       = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_WORKERS * QUEUE_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int STAG_W      = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int ENTRY_W     = STAG_W + HANDLER_W;
    localparam int SCAN_N      = (NUM_WORKERS < 7) ? NUM_WORKERS : 7;

    typedef enum logic [1:0] {
        BK_SEL = 2'b01,
        BK_FIN = 2'b10
    } bk_state_t;

    bk_state_t state_reg, state_next;

    logic [SLOT_W-1:0] head_reg [NUM_WORKERS];
    logic [SLOT_W-1:0] tail_reg [NUM_WORKERS];
    logic [CNT_W-1:0]  cnt_reg  [NUM_WORKERS];

    logic [ENTRY_W-1:0] job_store [STORE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // selection stage results
    kind_t              kind_reg;
    status_t            status_reg;
    logic [WID_W-1:0]   w_reg;
    logic [ID_W-1:0]    id_reg;
    logic               idle_reg;
    logic [CNT_W-1:0]   csel_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [HANDLER_W-1:0] handler_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic               out_idle_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [HANDLER_W-1:0] out_handler_reg;
    logic [LEVEL_W-1:0] out_level_reg;

    logic               sel_go, fin_go;
    logic [WID_W-1:0]   pop_w;
    logic [WID_W-1:0]   scan_w;
    logic [CNT_W-1:0]   scan_min;
    logic               scan_idle;
    logic               scan_done;
    kind_t              sel_kind;
    status_t            sel_status;
    logic [WID_W-1:0]   sel_w;
    logic [ID_W-1:0]    sel_id;
    logic               sel_idle;
    logic [CNT_W-1:0]   sel_cnt;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               pop_ok;
    logic [CNT_W-1:0]   level;
    logic [TAG_W-1:0]   fin_tag;
    logic [HANDLER_W-1:0] fin_handler;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [WID_W-1:0] w,
                                                      input logic [SLOT_W-1:0] slot);
        store_addr = ADDR_W'(w) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        next_slot = (slot == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    assign q_ready = (state_reg == BK_SEL);
    assign sel_go  = (state_reg == BK_SEL) && q_valid;
    assign fin_go  = (state_reg == BK_FIN) && (!out_valid_reg || m_tready);
    assign pop_w   = WID_W'(q_item.sel);

    // first empty active worker, else first with the smallest count
    always_comb
    begin
        scan_w    = '0;
        scan_min  = cnt_reg[0];
        scan_idle = 1'b0;
        scan_done = 1'b0;
        for (int i = 0; i < SCAN_N; i++)
        begin
            if (!scan_done && (i < int'(q_item.nact)))
            begin
                if (cnt_reg[i] == '0)
                begin
                    scan_w    = WID_W'(i);
                    scan_min  = '0;
                    scan_idle = 1'b1;
                    scan_done = 1'b1;
                end
                else if (cnt_reg[i] < scan_min)
                begin
                    scan_w   = WID_W'(i);
                    scan_min = cnt_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        sel_kind   = q_item.kind;
        sel_w      = '0;
        sel_id     = '0;
        sel_idle   = 1'b0;
        sel_cnt    = '0;
        sel_status = ST_OK;
        unique case (q_item.kind)
            K_SUBMIT:
            begin
                sel_w      = scan_w;
                sel_id     = ID_W'(scan_w);
                sel_idle   = scan_idle;
                sel_cnt    = scan_min;
                sel_status = (int'(scan_min) >= QUEUE_DEPTH) ? ST_FULL : ST_OK;
            end
            K_POP:
            begin
                sel_w      = pop_w;
                sel_id     = q_item.sel;
                sel_cnt    = cnt_reg[pop_w];
                sel_status = (cnt_reg[pop_w] == '0) ? ST_EMPTY : ST_OK;
            end
            K_NO_WORKER:
                sel_status = ST_NO_WORKER;
            K_POP_NONE:
            begin
                sel_id     = q_item.sel;
                sel_status = ST_EMPTY;
            end
            default:
                sel_status = ST_EMPTY;
        endcase
    end

    assign rd_en   = sel_go && (q_item.kind == K_POP) && (cnt_reg[pop_w] != '0);
    assign rd_addr = store_addr(pop_w, head_reg[pop_w]);
    assign wr_en   = fin_go && (kind_reg == K_SUBMIT) && (status_reg == ST_OK);
    assign wr_addr = store_addr(w_reg, tail_reg[w_reg]);
    assign pop_ok  = fin_go && (kind_reg == K_POP) && (status_reg == ST_OK);

    always_comb
    begin
        level       = '0;
        fin_tag     = '0;
        fin_handler = '0;
        if (status_reg == ST_OK && kind_reg == K_SUBMIT)
            level = csel_reg + 1'b1;
        else if (status_reg == ST_OK && kind_reg == K_POP)
        begin
            level       = csel_reg - 1'b1;
            fin_tag     = TAG_W'(rd_data_reg[ENTRY_W-1:HANDLER_W]);
            fin_handler = rd_data_reg[HANDLER_W-1:0];
        end
        else if (status_reg == ST_FULL)
            level = csel_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_SEL:  if (sel_go) state_next = BK_FIN;
            BK_FIN:  if (fin_go) state_next = BK_SEL;
            default: state_next = BK_SEL;
        endcase
        out_valid_next = fin_go || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_SEL;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_WORKERS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                tail_reg[w_reg] <= next_slot(tail_reg[w_reg]);
                cnt_reg[w_reg]  <= csel_reg + 1'b1;
            end
            if (pop_ok)
            begin
                head_reg[w_reg] <= next_slot(head_reg[w_reg]);
                cnt_reg[w_reg]  <= csel_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_go)
        begin
            kind_reg    <= sel_kind;
            status_reg  <= sel_status;
            w_reg       <= sel_w;
            id_reg      <= sel_id;
            idle_reg    <= sel_idle;
            csel_reg    <= sel_cnt;
            tag_reg     <= q_item.tag;
            handler_reg <= q_item.handler;
        end
        if (fin_go)
        begin
            out_status_reg  <= status_reg;
            out_id_reg      <= id_reg;
            out_idle_reg    <= idle_reg;
            out_tag_reg     <= fin_tag;
            out_handler_reg <= fin_handler;
            out_level_reg   <= LEVEL_W'(level);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            job_store[wr_addr] <= {tag_reg[STAG_W-1:0], handler_reg};
        if (rd_en)
            rd_data_reg <= job_store[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_level_reg, out_handler_reg, out_tag_reg, out_idle_reg, out_id_reg};

`ifndef SYNTHESIS
    a_fin_returns: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (state_reg == BK_SEL))
        else $error("back end did not return to selection after finishing");

    a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fin_go))
        else $error("result appeared without a finished transaction");

    a_count_update: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] != $past(cnt_reg[0])) |-> $past(fin_go))
        else $error("worker count changed outside the finish step");
`endif

endmodule
`default_nettype wire
